// ===== rtl/aip_pkg.sv =====
// Shared types, constants and helper functions for the ASCII integer parser.
package aip_pkg;

    localparam int unsigned CFG_DATA_W          = 11;
    localparam int unsigned CFG_INDEX_W         = 2;
    localparam int unsigned DEFAULT_MAX_WIDTH_C = 1024;
    localparam int unsigned VALUE_W             = 64;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_MODE       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_WIDTH       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_UNSIGNED_RESULT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RESULT_SIZE     = 2'd3;

    // Base codes, shared by base_mode and the active base of a number.
    localparam logic [1:0] BASE_AUTO = 2'd0;
    localparam logic [1:0] BASE_DEC  = 2'd1;
    localparam logic [1:0] BASE_OCT  = 2'd2;
    localparam logic [1:0] BASE_HEX  = 2'd3;

    // Result size codes.
    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    // Character codes.
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [7:0] CHAR_UPPER_X = 8'h58;
    localparam logic [7:0] CHAR_LOWER_X = 8'h78;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;

    // Digit value meaning "not a hex digit".
    localparam logic [4:0] NO_DIGIT = 5'd16;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               status;
        logic               char_consumed;
    } result_t;

    typedef struct packed {
        logic [1:0] base_mode;
        logic       unsigned_result;
        logic [1:0] result_size;
    } cfg_t;

    function automatic logic is_white(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if ((c >= CHAR_ZERO) && (c <= CHAR_NINE))
        begin
            d = c - CHAR_ZERO;
        end
        else if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F))
        begin
            d = c - CHAR_UPPER_A + 8'd10;
        end
        else if ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F))
        begin
            d = c - CHAR_LOWER_A + 8'd10;
        end
        else
        begin
            d = {3'b000, NO_DIGIT};
        end
        return d[4:0];
    endfunction

    // Truncate to the selected size, then sign- or zero-extend to 64 bits.
    function automatic logic [VALUE_W-1:0] shape(input logic [VALUE_W-1:0] v,
                                                 input logic [1:0]         size,
                                                 input logic               uns);
        logic [VALUE_W-1:0] r;
        r = v;
        case (size)
            SIZE_8:  r = {{56{v[7]  & ~uns}}, v[7:0]};
            SIZE_16: r = {{48{v[15] & ~uns}}, v[15:0]};
            SIZE_32: r = {{32{v[31] & ~uns}}, v[31:0]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/aip_engine.sv =====
// Parse state and single-pass next-state logic for one character per cycle while advance is set.
module aip_engine import aip_pkg::*;
#(
    parameter int unsigned MW_W = CFG_DATA_W
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  item_t           item,
    input  cfg_t            cfg,
    input  logic [MW_W-1:0] max_width,
    output logic            emit,
    output result_t         result
);

    logic                phase_reg, phase_next;
    logic [VALUE_W-1:0]  acc_reg, acc_next;
    logic [VALUE_W-1:0]  nacc_reg, nacc_next;
    logic                neg_reg, neg_next;
    logic                sign_ok_reg, sign_ok_next;
    logic                zseen_reg, zseen_next;
    logic                pfin_reg, pfin_next;
    logic [1:0]          abase_reg, abase_next;
    logic [MW_W-1:0]     cnt_reg, cnt_next;

    logic [4:0]          digit;
    logic [VALUE_W-1:0]  d64;
    logic                is_x;
    logic                is_sign;
    logic                take_en;
    logic                ok;
    logic                restart;
    logic [1:0]          bsel;
    logic [MW_W:0]       cnt_inc;
    logic [VALUE_W-1:0]  acc_dec, nacc_dec, acc_oct, nacc_oct, acc_hex, nacc_hex;

    assign digit   = digit_of(item.char_code);
    assign d64     = {{(VALUE_W-4){1'b0}}, digit[3:0]};
    assign is_x    = (item.char_code == CHAR_LOWER_X) || (item.char_code == CHAR_UPPER_X);
    assign is_sign = (item.char_code == CHAR_MINUS) || (item.char_code == CHAR_PLUS);
    assign cnt_inc = {1'b0, cnt_reg} + {{MW_W{1'b0}}, 1'b1};

    // The negated accumulator is kept alongside the accumulator, so a negative
    // result never needs a second wide add after the digit step.
    assign acc_dec  = {acc_reg[VALUE_W-4:0], 3'b000} + {acc_reg[VALUE_W-2:0], 1'b0} + d64;
    assign nacc_dec = {nacc_reg[VALUE_W-4:0], 3'b000} + {nacc_reg[VALUE_W-2:0], 1'b0} - d64;
    assign acc_oct  = {acc_reg[VALUE_W-4:0], 3'b000} | d64;
    assign nacc_oct = {nacc_reg[VALUE_W-4:0], 3'b000} - d64;
    assign acc_hex  = {acc_reg[VALUE_W-5:0], 4'b0000} | d64;
    assign nacc_hex = {nacc_reg[VALUE_W-5:0], 4'b0000} - d64;

    always_comb
    begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        nacc_next     = nacc_reg;
        neg_next      = neg_reg;
        sign_ok_next  = sign_ok_reg;
        zseen_next    = zseen_reg;
        pfin_next     = pfin_reg;
        abase_next    = abase_reg;
        cnt_next      = cnt_reg;
        emit          = 1'b0;
        restart       = 1'b0;
        take_en       = 1'b0;
        ok            = 1'b0;
        bsel          = phase_reg ? abase_reg : cfg.base_mode;
        result.status        = 1'b0;
        result.char_consumed = 1'b0;

        if (!phase_reg)
        begin
            if (item.end_of_input)
            begin
                emit          = 1'b1;
                result.status = 1'b1;
                restart       = 1'b1;
            end
            else if (!is_white(item.char_code))
            begin
                take_en    = 1'b1;
                phase_next = 1'b1;
                abase_next = cfg.base_mode;
            end
        end
        else if (item.end_of_input)
        begin
            emit    = 1'b1;
            restart = 1'b1;
        end
        else
        begin
            take_en = 1'b1;
        end

        if (take_en)
        begin
            sign_ok_next = 1'b0;
            if (sign_ok_reg && is_sign)
            begin
                neg_next = (item.char_code == CHAR_MINUS);
                ok       = 1'b1;
            end
            else
            begin
                case (bsel)
                    BASE_AUTO:
                    begin
                        if (!zseen_reg)
                        begin
                            if (item.char_code == CHAR_ZERO)
                            begin
                                zseen_next = 1'b1;
                                ok         = 1'b1;
                            end
                            else if ((digit >= 5'd1) && (digit <= 5'd9))
                            begin
                                acc_next   = d64;
                                nacc_next  = {VALUE_W{1'b0}} - d64;
                                abase_next = BASE_DEC;
                                ok         = 1'b1;
                            end
                        end
                        else if (is_x)
                        begin
                            abase_next = BASE_HEX;
                            pfin_next  = 1'b1;
                            ok         = 1'b1;
                        end
                        else if (digit < 5'd8)
                        begin
                            acc_next   = d64;
                            nacc_next  = {VALUE_W{1'b0}} - d64;
                            abase_next = BASE_OCT;
                            ok         = 1'b1;
                        end
                    end
                    BASE_DEC:
                    begin
                        if (digit < 5'd10)
                        begin
                            acc_next  = acc_dec;
                            nacc_next = nacc_dec;
                            ok        = 1'b1;
                        end
                    end
                    BASE_OCT:
                    begin
                        if (digit < 5'd8)
                        begin
                            acc_next  = acc_oct;
                            nacc_next = nacc_oct;
                            ok        = 1'b1;
                        end
                    end
                    default:
                    begin
                        // An x right after the first zero closes the 0x prefix.
                        if (is_x && zseen_reg && !pfin_reg)
                        begin
                            pfin_next = 1'b1;
                            ok        = 1'b1;
                        end
                        else if (digit != NO_DIGIT)
                        begin
                            if (!pfin_reg)
                            begin
                                if ((digit == 5'd0) && !zseen_reg)
                                begin
                                    zseen_next = 1'b1;
                                end
                                else
                                begin
                                    pfin_next = 1'b1;
                                end
                            end
                            acc_next  = acc_hex;
                            nacc_next = nacc_hex;
                            ok        = 1'b1;
                        end
                    end
                endcase
            end

            if (!ok)
            begin
                emit    = 1'b1;
                restart = 1'b1;
            end
            else if (cnt_inc >= {1'b0, max_width})
            begin
                emit                 = 1'b1;
                result.char_consumed = 1'b1;
                restart              = 1'b1;
            end
            else
            begin
                cnt_next = cnt_inc[MW_W-1:0];
            end
        end

        result.value = result.status ? {VALUE_W{1'b0}} :
                       shape(neg_next ? nacc_next : acc_next,
                             cfg.result_size, cfg.unsigned_result);

        if (restart)
        begin
            phase_next   = 1'b0;
            acc_next     = {VALUE_W{1'b0}};
            nacc_next    = {VALUE_W{1'b0}};
            neg_next     = 1'b0;
            sign_ok_next = 1'b1;
            zseen_next   = 1'b0;
            pfin_next    = 1'b0;
            abase_next   = BASE_AUTO;
            cnt_next     = {MW_W{1'b0}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= 1'b0;
            acc_reg     <= {VALUE_W{1'b0}};
            nacc_reg    <= {VALUE_W{1'b0}};
            neg_reg     <= 1'b0;
            sign_ok_reg <= 1'b1;
            zseen_reg   <= 1'b0;
            pfin_reg    <= 1'b0;
            abase_reg   <= BASE_AUTO;
            cnt_reg     <= {MW_W{1'b0}};
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            nacc_reg    <= nacc_next;
            neg_reg     <= neg_next;
            sign_ok_reg <= sign_ok_next;
            zseen_reg   <= zseen_next;
            pfin_reg    <= pfin_next;
            abase_reg   <= abase_next;
            cnt_reg     <= cnt_next;
        end
    end

    // The two accumulators must always be exact negatives of each other.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (nacc_reg == ({VALUE_W{1'b0}} - acc_reg)))
        else $error("negated accumulator out of step");

    // A finished number leaves the parser in its starting state.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (advance && emit) |=> (!phase_reg && sign_ok_reg &&
                                            (cnt_reg == {MW_W{1'b0}})))
        else $error("parser not restarted after a result");

endmodule

// ===== rtl/ascii_integer_parser.sv =====
// Top level of the ASCII integer parser: request and result handshakes, configuration.
//
// The parser takes one character per request and returns one result for each
// parsed integer: it skips leading white space, takes an optional sign, reads
// digits in a fixed or detected base, and ends on a non-digit (reported as not
// consumed), at max_width characters, or at end of input. A request is taken
// every cycle while results are drained. The request ending the number is first
// held in the input register; once it moves on, the digit step writes the
// result register. While a result waits unaccepted no request moves on, so a
// slow result side stalls the input. The sustained rate of one character per
// cycle while results are drained is set by the single shift-add digit step,
// which runs with a parallel negated accumulator so that sign handling needs
// no second wide add. Configuration is written through cfg_we, cfg_index and
// cfg_data; the base is fixed when a number starts, the other registers act
// at once.
module ascii_integer_parser import aip_pkg::*;
#(
    parameter int unsigned DEFAULT_MAX_WIDTH = DEFAULT_MAX_WIDTH_C
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned MW_CLOG = $clog2(DEFAULT_MAX_WIDTH + 1);
    localparam int unsigned MW_W    = (MW_CLOG > CFG_DATA_W) ? MW_CLOG : CFG_DATA_W;

    logic            item_valid_reg;
    item_t           item_reg;
    logic            result_valid_reg;
    result_t         result_reg;
    logic            advance;
    logic            emit;
    result_t         step_result;
    cfg_t            cfg_reg;
    logic [MW_W-1:0] max_width_reg;

    // The held request moves on whenever the result register can take a result.
    assign advance      = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !item_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_mode       <= BASE_DEC;
            cfg_reg.unsigned_result <= 1'b0;
            cfg_reg.result_size     <= SIZE_32;
            max_width_reg           <= MW_W'(DEFAULT_MAX_WIDTH);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE_MODE:       cfg_reg.base_mode       <= cfg_data[1:0];
                REG_MAX_WIDTH:       max_width_reg           <= MW_W'(cfg_data);
                REG_UNSIGNED_RESULT: cfg_reg.unsigned_result <= cfg_data[0];
                REG_RESULT_SIZE:     cfg_reg.result_size     <= cfg_data[1:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            result_reg <= step_result;
        end
    end

    aip_engine #(
        .MW_W (MW_W)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (item_reg),
        .cfg       (cfg_reg),
        .max_width (max_width_reg),
        .emit      (emit),
        .result    (step_result)
    );

    // End of input always closes a number, so it must produce a result.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (advance && item_reg.end_of_input) |=> result_valid_reg)
        else $error("end of input produced no result");

    // The end-of-input status carries a zero value and never a consumed character.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (result_valid_reg && result_reg.status) |->
                     ((result_reg.value == {VALUE_W{1'b0}}) && !result_reg.char_consumed))
        else $error("status result with a value or a consumed character");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the ASCII integer parser.
`timescale 1ns / 1ps

module tb;
    import aip_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned FLUSH_CYCLES = 6;

    logic clk = 1'b0;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    item_t item;
    logic result_valid;
    logic result_ready;
    result_t result;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned items_sent;
    int unsigned error_count;
    int unsigned idle_cycles;

    // Parser state as predicted, with our own copy of the registers.
    logic [1:0] cfg_base;
    logic [10:0] cfg_width;
    logic cfg_uns;
    logic [1:0] cfg_size;
    logic in_number;
    logic [63:0] acc;
    logic neg;
    logic sign_ok;
    logic zero_seen;
    logic hex_prefix_closed;
    logic [1:0] num_base;
    logic [15:0] char_tally;

    result_t expected_numbers[$];

    ascii_integer_parser u_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void restart_number();
        in_number = 1'b0;
        acc = 64'd0;
        neg = 1'b0;
        sign_ok = 1'b1;
        zero_seen = 1'b0;
        hex_prefix_closed = 1'b0;
        num_base = BASE_AUTO;
        char_tally = 16'd0;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic logic [4:0] char_digit(input logic [7:0] c);
        logic [7:0] d;
        if ((c >= CHAR_ZERO) && (c <= CHAR_NINE))
        begin
            d = c - CHAR_ZERO;
        end
        else if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F))
        begin
            d = c - CHAR_UPPER_A + 8'd10;
        end
        else if ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F))
        begin
            d = c - CHAR_LOWER_A + 8'd10;
        end
        else
        begin
            d = 8'd16;
        end
        return d[4:0];
    endfunction

    function automatic logic [63:0] final_value();
        logic [63:0] v;
        logic [63:0] mask;
        int unsigned bits;
        v = neg ? (64'd0 - acc) : acc;
        if (cfg_size == SIZE_64)
        begin
            return v;
        end
        bits = 8 << cfg_size;
        mask = (64'd1 << bits) - 64'd1;
        v = v & mask;
        if (!cfg_uns && v[bits-1])
        begin
            v = v | ~mask;
        end
        return v;
    endfunction

    // Returns 1 when the character belongs to the number.
    function automatic logic accept_char(input logic [7:0] c);
        logic [4:0] d;
        logic is_x;
        d = char_digit(c);
        is_x = (c == CHAR_LOWER_X) || (c == CHAR_UPPER_X);
        if (sign_ok && ((c == CHAR_MINUS) || (c == CHAR_PLUS)))
        begin
            neg = (c == CHAR_MINUS);
            sign_ok = 1'b0;
            return 1'b1;
        end
        sign_ok = 1'b0;
        case (num_base)
            BASE_AUTO:
            begin
                if (!zero_seen)
                begin
                    if (c == CHAR_ZERO)
                    begin
                        zero_seen = 1'b1;
                        return 1'b1;
                    end
                    if ((d >= 5'd1) && (d <= 5'd9))
                    begin
                        acc = 64'(d);
                        num_base = BASE_DEC;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                if (is_x)
                begin
                    num_base = BASE_HEX;
                    hex_prefix_closed = 1'b1;
                    return 1'b1;
                end
                if (d < 5'd8)
                begin
                    acc = 64'(d);
                    num_base = BASE_OCT;
                    return 1'b1;
                end
                return 1'b0;
            end
            BASE_DEC:
            begin
                if (d >= 5'd10)
                begin
                    return 1'b0;
                end
                acc = acc * 64'd10 + 64'(d);
                return 1'b1;
            end
            BASE_OCT:
            begin
                if (d >= 5'd8)
                begin
                    return 1'b0;
                end
                acc = (acc << 3) | 64'(d);
                return 1'b1;
            end
            default:
            begin
                if (is_x && zero_seen && !hex_prefix_closed)
                begin
                    hex_prefix_closed = 1'b1;
                    return 1'b1;
                end
                if (d >= 5'd16)
                begin
                    return 1'b0;
                end
                if (!hex_prefix_closed)
                begin
                    if ((d == 5'd0) && !zero_seen)
                    begin
                        zero_seen = 1'b1;
                    end
                    else
                    begin
                        hex_prefix_closed = 1'b1;
                    end
                end
                acc = (acc << 4) | 64'(d);
                return 1'b1;
            end
        endcase
    endfunction

    // Advances the predicted parser by one request; queues a number when one ends.
    function automatic void predict_request(input item_t req);
        result_t r;
        logic done;
        done = 1'b0;
        r = '0;
        if (!in_number && req.end_of_input)
        begin
            r.status = 1'b1;
            done = 1'b1;
        end
        else if (!in_number && is_space(req.char_code))
        begin
            return;
        end
        else if (in_number && req.end_of_input)
        begin
            r.value = final_value();
            done = 1'b1;
        end
        else
        begin
            if (!in_number)
            begin
                in_number = 1'b1;
                num_base = cfg_base;
            end
            if (!accept_char(req.char_code))
            begin
                r.value = final_value();
                done = 1'b1;
            end
            else
            begin
                char_tally = char_tally + 16'd1;
                if (char_tally >= 16'(cfg_width))
                begin
                    r.value = final_value();
                    r.char_consumed = 1'b1;
                    done = 1'b1;
                end
            end
        end
        if (done)
        begin
            expected_numbers.push_back(r);
            restart_number();
        end
    endfunction

    task automatic send_item(input logic [7:0] c, input logic eoi);
        item_t req;
        req.char_code = c;
        req.end_of_input = eoi;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= req;
        do
            @(posedge clk);
        while (!item_ready);
        predict_request(req);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
        begin
            send_item(s[i], 1'b0);
        end
    endtask

    // Stops sending and waits until every predicted number has come back.
    task automatic wait_all_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_numbers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data[CFG_DATA_W-1:0];
        @(posedge clk);
        case (idx)
            REG_BASE_MODE: cfg_base = data[1:0];
            REG_MAX_WIDTH: cfg_width = data[10:0];
            REG_UNSIGNED_RESULT: cfg_uns = data[0];
            default: cfg_size = data[1:0];
        endcase
    endtask

    task automatic set_config(input logic [1:0] base, input int unsigned width,
                              input logic uns, input logic [1:0] size);
        write_reg(REG_BASE_MODE, base);
        write_reg(REG_MAX_WIDTH, width);
        write_reg(REG_UNSIGNED_RESULT, uns);
        write_reg(REG_RESULT_SIZE, size);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] random_digit(input logic [1:0] base);
        int unsigned sel;
        if (base == BASE_DEC)
        begin
            return CHAR_ZERO + 8'($urandom_range(9));
        end
        if (base == BASE_OCT)
        begin
            return CHAR_ZERO + 8'($urandom_range(7));
        end
        sel = $urandom_range(21);
        if (sel < 10)
        begin
            return CHAR_ZERO + 8'(sel);
        end
        if (sel < 16)
        begin
            return CHAR_LOWER_A + 8'(sel - 10);
        end
        return CHAR_UPPER_A + 8'(sel - 16);
    endfunction

    function automatic logic [7:0] random_stop();
        logic [7:0] stops[9];
        stops = '{CHAR_SPACE, ",", CHAR_MINUS, CHAR_PLUS, CHAR_LOWER_X, "G", "z",
                  8'hFF, 8'h00};
        return stops[$urandom_range(8)];
    endfunction

    // One well-formed number with random content, or now and then a stray byte.
    task automatic send_random_number();
        int unsigned sel;
        int unsigned n_digits;
        logic [1:0] kind;
        if ($urandom_range(9) == 0)
        begin
            send_item(8'($urandom_range(255)), $urandom_range(7) == 0);
            return;
        end
        repeat ($urandom_range(2))
        begin
            sel = $urandom_range(5);
            send_item((sel == 5) ? CHAR_SPACE : CHAR_TAB + 8'(sel), 1'b0);
        end
        sel = $urandom_range(3);
        if (sel == 0)
        begin
            send_item(CHAR_MINUS, 1'b0);
        end
        else if (sel == 1)
        begin
            send_item(CHAR_PLUS, 1'b0);
        end
        kind = cfg_base;
        if (kind == BASE_AUTO)
        begin
            kind = 2'($urandom_range(1, 3));
        end
        if ((kind == BASE_HEX) && ((cfg_base == BASE_AUTO) || ($urandom_range(1) == 1)))
        begin
            send_item(CHAR_ZERO, 1'b0);
            send_item(($urandom_range(1) == 1) ? CHAR_LOWER_X : CHAR_UPPER_X, 1'b0);
        end
        if ((kind == BASE_OCT) && (cfg_base == BASE_AUTO))
        begin
            send_item(CHAR_ZERO, 1'b0);
        end
        // Long runs of digits can make the accumulator wrap.
        n_digits = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(12);
        repeat (n_digits) send_item(random_digit(kind), 1'b0);
        case ($urandom_range(5))
            0: send_item(8'($urandom_range(255)), 1'b1);
            1: send_item(8'($urandom_range(255)), 1'b0);
            2: ;
            default: send_item(random_stop(), 1'b0);
        endcase
    endtask

    task automatic randomize_config();
        int unsigned width;
        case ($urandom_range(9))
            0: width = 1;
            1: width = 0;
            2: width = $urandom_range(2, 8);
            3, 4, 5: width = $urandom_range(9, 40);
            6: width = $urandom_range(64, 1023);
            default: width = DEFAULT_MAX_WIDTH_C;
        endcase
        set_config(2'($urandom_range(3)), width, 1'($urandom_range(1)),
                   2'($urandom_range(3)));
    endtask

    task automatic test_default_config();
        send_item(8'hFF, 1'b1);
        send_text("\t -42");
        send_item(8'hFF, 1'b0);
        // A sign after digits ends the number.
        send_text("7+");
        wait_all_results();
    endtask

    task automatic test_auto_prefixes();
        set_config(BASE_AUTO, 3, 1'b1, SIZE_8);
        send_text("0x");
        send_item(8'h00, 1'b1);
        send_text("09");
        send_text("0777");
        send_item(8'h00, 1'b0);
        wait_all_results();
    endtask

    task automatic test_hex_and_width();
        set_config(BASE_HEX, 0, 1'b0, SIZE_64);
        send_text("F");
        wait_all_results();
        set_config(BASE_HEX, DEFAULT_MAX_WIDTH_C, 1'b0, SIZE_16);
        send_text("0XaF");
        send_item(CHAR_SPACE, 1'b1);
        wait_all_results();
    endtask

    // The base chosen at the start of a number holds across a register change.
    task automatic test_base_held_mid_number();
        send_text(" -1");
        wait_all_results();
        set_config(BASE_DEC, DEFAULT_MAX_WIDTH_C, 1'b0, SIZE_64);
        send_text("bG");
        wait_all_results();
    endtask

    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                       input int unsigned n_items);
        int unsigned start;
        int unsigned group_end;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            wait_all_results();
            randomize_config();
            group_end = items_sent + $urandom_range(20, 60);
            while (items_sent < group_end)
            begin
                send_random_number();
            end
        end
        send_item(8'($urandom_range(255)), 1'b1);
        wait_all_results();
    endtask

    task automatic test_widest_number();
        set_config(BASE_DEC, DEFAULT_MAX_WIDTH_C, 1'b1, SIZE_64);
        repeat (DEFAULT_MAX_WIDTH_C) send_item(random_digit(BASE_DEC), 1'b0);
        send_text("5");
        send_item(8'h00, 1'b1);
        wait_all_results();
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_numbers.size() == 0)
            begin
                $error("unexpected result: value %h status %b consumed %b",
                       result.value, result.status, result.char_consumed);
                error_count++;
            end
            else
            begin
                want = expected_numbers.pop_front();
                if (result.value !== want.value)
                begin
                    $error("value mismatch: expected %h, got %h", want.value, result.value);
                    error_count++;
                end
                if (result.status !== want.status)
                begin
                    $error("status mismatch: expected %b, got %b", want.status,
                           result.status);
                    error_count++;
                end
                if (result.char_consumed !== want.char_consumed)
                begin
                    $error("char_consumed mismatch: expected %b, got %b",
                           want.char_consumed, result.char_consumed);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready) || cfg_we)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        items_sent = 0;
        error_count = 0;
        idle_cycles = 0;
        send_idle_pct = 32;
        recv_idle_pct = 88;
        cfg_base = BASE_DEC;
        cfg_width = 11'(DEFAULT_MAX_WIDTH_C);
        cfg_uns = 1'b0;
        cfg_size = SIZE_32;
        restart_number();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_config();
        test_auto_prefixes();
        test_hex_and_width();
        test_base_held_mid_number();
        test_random_traffic(32, 88, 170);
        test_random_traffic(88, 32, 170);
        test_random_traffic(0, 0, 170);
        test_widest_number();

        if (error_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
